// File: hdl/text_cell_to_pixel_renderer_assert.svh
// Assertion macros for the text cell renderer
`ifndef TEXT_CELL_TO_PIXEL_RENDERER_ASSERT_SVH
`define TEXT_CELL_TO_PIXEL_RENDERER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TCPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TCPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/tcpr_pkg.sv
// Constants and codes shared by the text cell renderer
`default_nettype none
package tcpr_pkg;
	localparam int GLYPH_WIDTH  = 6;
	localparam int GLYPH_HEIGHT = 8;
	localparam int GLYPH_COUNT  = 256;
	localparam int PAL_ENTRIES  = 16;
	localparam int GLYPH_PIXELS = GLYPH_WIDTH * GLYPH_HEIGHT;
	localparam int FONT_BITS    = GLYPH_COUNT * GLYPH_PIXELS;
	localparam int FA_W         = $clog2(FONT_BITS);

	localparam int FUNC_W  = 2;
	localparam int GLYPH_W = 8;
	localparam int PIDX_W  = 6;
	localparam int PAL_W   = 4;
	localparam int COLOR_W = 24;
	localparam int ATTR_W  = 8;
	localparam int CELL_W  = 12;
	localparam int SW_W    = 7;
	localparam int X_W     = 9;
	localparam int Y_W     = 15;
	localparam int GC_W    = 3;
	localparam int DC_W    = 4;

	localparam logic [SW_W-1:0] SW_RESET = 7'd32;
	localparam logic [SW_W-1:0] SW_MAX   = 7'd64;

	localparam logic [FUNC_W-1:0] FUNC_FONT    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_PALETTE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DRAW    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;
endpackage
`default_nettype wire

// File: hdl/text_cell_to_pixel_renderer.sv
// Text-mode character generator: font and palette stores, cell to pixel expansion
// Usage:
//   Command channel: a word is taken at a clock edge with start high and busy low.
//   func selects font pixel write, palette color write or cell draw; func 3 is a no-op.
//   Writes produce nothing; busy stays low after them.
//   A draw splits cell_index into column and row with a 12-step shift-subtract
//   divider, then walks the glyph one pixel a cycle through the font memory.
//   Pixels come out on pixel_x, pixel_y, pixel_color, last, each valid for
//   one cycle with strobe; last marks the 48th pixel.
//   A pixel passes the EMIT state, then the vld_s1 and strobe registers. The
//   next word can be taken once the state is idle and vld_s1 is low, the final
//   pixel then on the outputs; the divider and single font read port pace a draw.
//   cfg_we/cfg_data write the screen width in cells (0 acts as 1, above 64 as 64);
//   write it only while the block is idle.
//   Reset clears control and sets the width to 32; font and palette are undefined
//   until written. The receiver cannot stall: pixels are never held.
`default_nettype none
module text_cell_to_pixel_renderer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [tcpr_pkg::SW_W-1:0]       cfg_data,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [tcpr_pkg::FUNC_W-1:0]     func,
	input  wire logic [tcpr_pkg::GLYPH_W-1:0]    glyph,
	input  wire logic [tcpr_pkg::PIDX_W-1:0]     pixel_index,
	input  wire logic                            pixel_bit,
	input  wire logic [tcpr_pkg::PAL_W-1:0]      palette_index,
	input  wire logic [tcpr_pkg::COLOR_W-1:0]    color_value,
	input  wire logic [tcpr_pkg::ATTR_W-1:0]     attribute,
	input  wire logic [tcpr_pkg::CELL_W-1:0]     cell_index,
	output logic                                 strobe,
	output logic [tcpr_pkg::X_W-1:0]             pixel_x,
	output logic [tcpr_pkg::Y_W-1:0]             pixel_y,
	output logic [tcpr_pkg::COLOR_W-1:0]         pixel_color,
	output logic                                 last
);
	import tcpr_pkg::*;

	`include "text_cell_to_pixel_renderer_assert.svh"

	logic                 font_mem [FONT_BITS];
	logic [COLOR_W-1:0]   pal_mem  [PAL_ENTRIES];

	state_t               state_q;
	logic [SW_W-1:0]      width_q;
	logic [SW_W-1:0]      div_w_q;
	logic [SW_W-1:0]      rem_q;
	logic [CELL_W-1:0]    div_n_q;
	logic [DC_W-1:0]      div_cnt_q;
	logic                 glyph_ok_q;
	logic [ATTR_W-1:0]    attr_q;
	logic [FA_W-1:0]      font_addr_q;
	logic [PIDX_W-1:0]    pix_q;
	logic [GC_W-1:0]      gx_q;
	logic [GC_W-1:0]      gy_q;
	logic [COLOR_W-1:0]   fg_q;
	logic [COLOR_W-1:0]   bg_q;
	logic                 font_rd_q;

	logic                 vld_s1;
	logic [X_W-1:0]       x_s1;
	logic [Y_W-1:0]       y_s1;
	logic                 last_s1;

	logic                 accept;
	logic                 font_wr;
	logic                 pal_wr;
	logic [SW_W-1:0]      w_clamp;
	logic [SW_W-1:0]      trial;
	logic                 trial_ge;
	logic [X_W-1:0]       x_base;
	logic [Y_W-1:0]       y_base;
	logic                 emit_end;
	logic                 fg_ok;
	logic                 bg_ok;

	assign busy   = (state_q != ST_IDLE) || vld_s1;
	assign accept = start && !busy;

	assign font_wr = accept && (func == FUNC_FONT)
		&& ({1'b0, glyph} < (GLYPH_W + 1)'(GLYPH_COUNT))
		&& ({1'b0, pixel_index} < (PIDX_W + 1)'(GLYPH_PIXELS));
	assign pal_wr  = accept && (func == FUNC_PALETTE)
		&& ({1'b0, palette_index} < (PAL_W + 1)'(PAL_ENTRIES));

	always_comb begin
		if (width_q == '0) begin
			w_clamp = SW_W'(1);
		end else if (width_q > SW_MAX) begin
			w_clamp = SW_MAX;
		end else begin
			w_clamp = width_q;
		end
	end

	// restoring divide step: one quotient bit per cycle
	assign trial    = {rem_q[SW_W-2:0], div_n_q[CELL_W-1]};
	assign trial_ge = trial >= div_w_q;

	assign x_base   = X_W'(rem_q[SW_W-2:0]) * X_W'(GLYPH_WIDTH);
	assign y_base   = Y_W'(div_n_q) * Y_W'(GLYPH_HEIGHT);
	assign emit_end = pix_q == PIDX_W'(GLYPH_PIXELS - 1);

	assign fg_ok = {1'b0, attr_q[3:0]} < (PAL_W + 1)'(PAL_ENTRIES);
	assign bg_ok = {1'b0, attr_q[7:4]} < (PAL_W + 1)'(PAL_ENTRIES);

	always_ff @(posedge clk) begin
		if (font_wr) begin
			font_mem[FA_W'(glyph) * FA_W'(GLYPH_PIXELS) + FA_W'(pixel_index)] <= pixel_bit;
		end
		font_rd_q <= font_mem[font_addr_q];
	end

	always_ff @(posedge clk) begin
		if (pal_wr) begin
			pal_mem[palette_index] <= color_value;
		end
		if (state_q == ST_DIV) begin
			fg_q <= fg_ok ? pal_mem[attr_q[3:0]] : '0;
			bg_q <= bg_ok ? pal_mem[attr_q[7:4]] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SW_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
			pix_q     <= '0;
			gx_q      <= '0;
			gy_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					div_cnt_q <= '0;
					pix_q     <= '0;
					gx_q      <= '0;
					gy_q      <= '0;
					if (accept && (func == FUNC_DRAW)) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DC_W'(1);
					if (div_cnt_q == DC_W'(CELL_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					pix_q <= pix_q + PIDX_W'(1);
					if (gx_q == GC_W'(GLYPH_WIDTH - 1)) begin
						gx_q <= '0;
						gy_q <= gy_q + GC_W'(1);
					end else begin
						gx_q <= gx_q + GC_W'(1);
					end
					if (emit_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (func == FUNC_DRAW)) begin
			div_w_q     <= w_clamp;
			rem_q       <= '0;
			div_n_q     <= cell_index;
			glyph_ok_q  <= {1'b0, glyph} < (GLYPH_W + 1)'(GLYPH_COUNT);
			attr_q      <= attribute;
			font_addr_q <= FA_W'(glyph) * FA_W'(GLYPH_PIXELS);
		end else if (state_q == ST_DIV) begin
			rem_q   <= trial_ge ? trial - div_w_q : trial;
			div_n_q <= {div_n_q[CELL_W-2:0], trial_ge};
		end else if (state_q == ST_EMIT) begin
			font_addr_q <= font_addr_q + FA_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			strobe <= 1'b0;
		end else begin
			vld_s1 <= state_q == ST_EMIT;
			strobe <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_base + X_W'(gx_q);
		y_s1    <= y_base + Y_W'(gy_q);
		last_s1 <= emit_end;
		pixel_x <= x_s1;
		pixel_y <= y_s1;
		last    <= last_s1;
		pixel_color <= (font_rd_q && glyph_ok_q) ? fg_q : bg_q;
	end

	`TCPR_ASSERT_NOW(a_pending_pixel_busy, vld_s1, busy, "pixel in flight while not busy")
	`TCPR_ASSERT_NOW(a_last_drains, strobe && last, !vld_s1, "pixel follows the last pixel")
	`TCPR_ASSERT_NEXT(a_draw_divides, accept && (func == FUNC_DRAW), state_q == ST_DIV,
		"draw did not start the divider")
	`TCPR_ASSERT_NEXT(a_write_stays_idle, accept && (func != FUNC_DRAW), !busy,
		"write word left the block busy")
endmodule
`default_nettype wire

// File: sim/text_cell_to_pixel_renderer_tb.sv
// Self-checking testbench for the text cell renderer: font/palette loads, cell draws, width sweep
module text_cell_to_pixel_renderer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcpr_pkg::*;

	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [GLYPH_W-1:0] glyph;
		logic [PIDX_W-1:0]  pidx;
		logic               pbit;
		logic [PAL_W-1:0]   pal;
		logic [COLOR_W-1:0] color;
		logic [ATTR_W-1:0]  attr;
		logic [CELL_W-1:0]  cell_idx;
	} word_t;

	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pixel_t;

	typedef enum {ROW_WORD, ROW_WIDTH} row_kind_t;

	typedef struct {
		row_kind_t kind;
		word_t     w;
		int        width;
		bit        typed;
		int        x0;
		int        y0;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [SW_W-1:0]    cfg_data = '0;
	logic               start = 1'b0;
	logic [FUNC_W-1:0]  func = '0;
	logic [GLYPH_W-1:0] glyph = '0;
	logic [PIDX_W-1:0]  pixel_index = '0;
	logic               pixel_bit = 1'b0;
	logic [PAL_W-1:0]   palette_index = '0;
	logic [COLOR_W-1:0] color_value = '0;
	logic [ATTR_W-1:0]  attribute = '0;
	logic [CELL_W-1:0]  cell_index = '0;
	logic               busy;
	logic               strobe;
	logic [X_W-1:0]     pixel_x;
	logic [Y_W-1:0]     pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               last;

	// shadow of the font atlas, palette and width register
	bit                 font_bits [FONT_BITS];
	bit                 font_set [FONT_BITS];
	int                 glyph_fill [GLYPH_COUNT];
	int                 ready_glyphs [$];
	logic [COLOR_W-1:0] pal_colors [PAL_ENTRIES];
	logic [SW_W-1:0]    width_reg = SW_RESET;

	pixel_t pixel_q [$];
	pixel_t want;
	row_t   plan [$];
	int     errors = 0;
	int     words_sent = 0;
	int     draws_sent = 0;
	int     pixels_seen = 0;
	int     idle_pct = 21;

	text_cell_to_pixel_renderer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.func          (func),
		.glyph         (glyph),
		.pixel_index   (pixel_index),
		.pixel_bit     (pixel_bit),
		.palette_index (palette_index),
		.color_value   (color_value),
		.attribute     (attribute),
		.cell_index    (cell_index),
		.strobe        (strobe),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.last          (last)
	);

	always #5 clk = ~clk;

	function automatic word_t rand_word();
		word_t w;
		w.func     = FUNC_NOP;
		w.glyph    = GLYPH_W'($urandom);
		w.pidx     = PIDX_W'($urandom);
		w.pbit     = 1'($urandom);
		w.pal      = PAL_W'($urandom);
		w.color    = COLOR_W'($urandom);
		w.attr     = ATTR_W'($urandom);
		w.cell_idx = CELL_W'($urandom);
		return w;
	endfunction

	function automatic word_t font_word(int g, int pix, int b);
		word_t w;
		w = rand_word();
		w.func  = FUNC_FONT;
		w.glyph = GLYPH_W'(g);
		w.pidx  = PIDX_W'(pix);
		w.pbit  = 1'(b);
		return w;
	endfunction

	function automatic word_t pal_word(int idx, int c);
		word_t w;
		w = rand_word();
		w.func  = FUNC_PALETTE;
		w.pal   = PAL_W'(idx);
		w.color = COLOR_W'(c);
		return w;
	endfunction

	function automatic word_t draw_word(int g, int a, int cell_i);
		word_t w;
		w = rand_word();
		w.func     = FUNC_DRAW;
		w.glyph    = GLYPH_W'(g);
		w.attr     = ATTR_W'(a);
		w.cell_idx = CELL_W'(cell_i);
		return w;
	endfunction

	function automatic row_t word_row(word_t w, bit typed = 1'b0, int x0 = 0, int y0 = 0);
		row_t r;
		r.kind  = ROW_WORD;
		r.w     = w;
		r.width = 0;
		r.typed = typed;
		r.x0    = x0;
		r.y0    = y0;
		return r;
	endfunction

	function automatic row_t width_row(int v);
		row_t r;
		r = word_row(rand_word());
		r.kind  = ROW_WIDTH;
		r.width = v;
		return r;
	endfunction

	// update the shadow state for one accepted word and queue the pixels it draws;
	// typed rows supply the cell origin instead of deriving it from the width
	function automatic void render_word(word_t w, bit typed, int x0, int y0);
		int cw, col, row, cell_i, p, addr;
		logic [COLOR_W-1:0] fg, bg;
		pixel_t px;
		case (w.func)
		FUNC_FONT: begin
			if (w.pidx < GLYPH_PIXELS) begin
				addr = int'(w.glyph) * GLYPH_PIXELS + int'(w.pidx);
				font_bits[addr] = w.pbit;
				if (!font_set[addr]) begin
					font_set[addr] = 1'b1;
					glyph_fill[w.glyph]++;
					if (glyph_fill[w.glyph] == GLYPH_PIXELS)
						ready_glyphs.push_back(int'(w.glyph));
				end
			end
		end
		FUNC_PALETTE: begin
			pal_colors[w.pal] = w.color;
		end
		FUNC_DRAW: begin
			cw = (width_reg == '0) ? 1 : (width_reg > SW_MAX) ? int'(SW_MAX) : int'(width_reg);
			cell_i = int'(w.cell_idx);
			col = cell_i % cw;
			row = cell_i / cw;
			if (!typed) begin
				x0 = col * GLYPH_WIDTH;
				y0 = row * GLYPH_HEIGHT;
			end
			fg = pal_colors[w.attr[3:0]];
			bg = pal_colors[w.attr[7:4]];
			for (p = 0; p < GLYPH_PIXELS; p++) begin
				px.x     = X_W'(x0 + p % GLYPH_WIDTH);
				px.y     = Y_W'(y0 + p / GLYPH_WIDTH);
				px.color = font_bits[int'(w.glyph) * GLYPH_PIXELS + p] ? fg : bg;
				px.last  = (p == GLYPH_PIXELS - 1);
				pixel_q.push_back(px);
			end
			draws_sent++;
		end
		default: ;
		endcase
	endfunction

	task automatic send_word(input word_t w, input bit typed = 1'b0,
			input int x0 = 0, input int y0 = 0);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		func          <= w.func;
		glyph         <= w.glyph;
		pixel_index   <= w.pidx;
		pixel_bit     <= w.pbit;
		palette_index <= w.pal;
		color_value   <= w.color;
		attribute     <= w.attr;
		cell_index    <= w.cell_idx;
		@(posedge clk);
		while (busy) @(posedge clk);
		render_word(w, typed, x0, y0);
		words_sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pixel_q.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(input int v);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_data <= SW_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = SW_W'(v);
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			pixels_seen++;
			if (pixel_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel x=%0d y=%0d color=%06h last=%0b",
					$time, pixel_x, pixel_y, pixel_color, last);
			end else begin
				want = pixel_q.pop_front();
				if (pixel_x !== want.x || pixel_y !== want.y ||
						pixel_color !== want.color || last !== want.last) begin
					errors++;
					$display("%0t: pixel mismatch exp x=%0d y=%0d color=%06h last=%0b, got x=%0d y=%0d color=%06h last=%0b",
						$time, want.x, want.y, want.color, want.last,
						pixel_x, pixel_y, pixel_color, last);
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("timeout with %0d pixels outstanding", pixel_q.size());
		$display("** text_cell_to_pixel_renderer: FAILED **");
		$finish;
	end

	initial begin
		int p, ph, n, pick, g;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bring-up: whole palette, glyph 0 and 1 as stripes, glyph 255 random
		for (p = 0; p < PAL_ENTRIES; p++)
			send_word(pal_word(p, int'($urandom_range(24'hFFFFFF))));
		for (p = 0; p < GLYPH_PIXELS; p++) begin
			send_word(font_word(0, p, 1 - p % 2));
			send_word(font_word(1, p, p % 2));
			send_word(font_word(255, p, int'($urandom_range(1))));
		end

		plan.push_back(word_row(pal_word(0, 0)));
		plan.push_back(word_row(pal_word(15, 24'hFFFFFF)));
		// pixel positions past the glyph are dropped; glyph 1 would show a leak
		plan.push_back(word_row(font_word(0, 49, 0)));
		plan.push_back(word_row(font_word(0, 63, 0)));
		plan.push_back(word_row(font_word(255, 63, 1)));
		plan.push_back(word_row('1));
		plan.push_back(word_row(draw_word(1, 8'hF0, 0), 1'b1, 0, 0));
		plan.push_back(word_row(draw_word(0, 8'h0F, 4095), 1'b1, 186, 1016));
		plan.push_back(word_row(draw_word(255, int'($urandom_range(255)), 31), 1'b1, 186, 0));
		plan.push_back(width_row(1));
		plan.push_back(word_row(draw_word(0, 8'hFF, 4095), 1'b1, 0, 32760));
		plan.push_back(word_row(draw_word(1, 8'h00, 0), 1'b1, 0, 0));
		plan.push_back(width_row(64));
		plan.push_back(word_row(draw_word(255, 8'h3C, 4095), 1'b1, 378, 504));
		plan.push_back(word_row(draw_word(1, 8'hC3, 64), 1'b1, 0, 8));
		plan.push_back(width_row(0));
		plan.push_back(word_row(draw_word(0, 8'h81, 4095), 1'b1, 0, 32760));
		plan.push_back(width_row(127));
		plan.push_back(word_row(draw_word(1, 8'h18, 4095), 1'b1, 378, 504));
		plan.push_back(width_row(65));
		plan.push_back(word_row(draw_word(1, 8'hE7, 127), 1'b1, 378, 8));
		plan.push_back(word_row(font_word(255, 47, 1)));
		plan.push_back(word_row(draw_word(255, 8'h5A, 100), 1'b1, 216, 8));
		plan.push_back(word_row(pal_word(15, 24'h123456)));
		plan.push_back(word_row(draw_word(1, 8'hF0, 0), 1'b1, 0, 0));

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WIDTH)
				set_width(plan[i].width);
			else
				send_word(plan[i].w, plan[i].typed, plan[i].x0, plan[i].y0);
		end

		for (ph = 0; ph < 6; ph++) begin
			case (ph)
			0: set_width(int'($urandom_range(2, 63)));
			1: set_width(int'(SW_MAX));
			2: set_width(1);
			3: set_width(13);
			4: set_width(int'($urandom_range(0, 127)));
			default: set_width(int'(SW_RESET));
			endcase
			idle_pct = (ph == 1) ? 0 : 21;
			if (ph == 0) begin
				g = int'($urandom_range(2, 254));
				for (p = 0; p < GLYPH_PIXELS; p++)
					send_word(font_word(g, p, int'($urandom_range(1))));
			end
			for (n = 0; n < 28; n++) begin
				pick = int'($urandom_range(99));
				if (pick < 45)
					send_word(draw_word(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)],
						int'($urandom_range(255)), int'($urandom_range(4095))));
				else if (pick < 70)
					send_word(font_word(int'($urandom_range(255)), int'($urandom_range(63)),
						int'($urandom_range(1))));
				else if (pick < 80)
					send_word(font_word(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)],
						int'($urandom_range(47)), int'($urandom_range(1))));
				else if (pick < 94)
					send_word(pal_word(int'($urandom_range(15)), int'($urandom_range(24'hFFFFFF))));
				else
					send_word(rand_word());
				if (ph == 3 && n == 20)
					wait_idle();
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("run covered %0d words, %0d cell draws and %0d pixels", words_sent, draws_sent,
			pixels_seen);
		$display("widths 0 to 127, glyph bounds, palette extremes, back-to-back and gapped traffic");
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("** text_cell_to_pixel_renderer: PASSED **");
		end else begin
			$display("** text_cell_to_pixel_renderer: FAILED **");
		end
		$finish;
	end
endmodule
